// ===== src/smsq_pkg.sv =====
// Shared types, constants and the coil phase table of the stepper move sequencer.
`timescale 1ns / 1ps

package smsq_pkg;

   // Field widths fixed by the command and result formats.
   localparam int AmountWidth   = 24;
   localparam int IntervalWidth = 16;
   localparam int SprWidth      = 16;
   localparam int CoilWidth     = 4;
   localparam int PhaseWidth    = 3;
   localparam int StepsWidth    = 34;

   // Degree conversion splits steps_per_rev into quotient and remainder by 360.
   localparam int DegPerRev     = 360;
   localparam int SprQuotWidth  = 8;   // steps_per_rev / 360 is at most 182
   localparam int SprRemWidth   = 9;   // steps_per_rev % 360 is at most 359
   localparam int ProdQWidth    = AmountWidth + SprQuotWidth;
   localparam int ProdRWidth    = AmountWidth + SprRemWidth;
   localparam int DegCountWidth = 33;

   // Reciprocal of 45 for the remainder part: floor(n / 45) = (n * RECIP_45) >> 36
   // for every n below 2**30 (the remainder product is first shifted right by 3).
   localparam int                 Recip45Shift = 36;
   localparam logic [30:0]        RECIP_45     = 31'd1527099484;
   // Reciprocal of 45 for the configuration split, exact for n below 2**13.
   localparam int                 CfgRecipShift = 19;
   localparam logic [14:0]        CFG_RECIP_45  = 15'd11651;

   localparam logic [SprWidth-1:0] SPR_RESET     = 16'd200;
   localparam logic [SprRemWidth-1:0] SPR_REM_RESET = 9'd200;

   // Item kinds.
   localparam logic ACTION_MOVE = 1'b0;
   localparam logic ACTION_TICK = 1'b1;

   // Phase advance per step.
   localparam logic [PhaseWidth-1:0] DELTA_FULL = 3'd2;
   localparam logic [PhaseWidth-1:0] DELTA_HALF = 3'd1;

   typedef struct packed {
      logic                     action;
      logic [AmountWidth-1:0]   amount;
      logic                     in_degrees;
      logic                     counter_clockwise;
      logic                     half_mode;
      logic [IntervalWidth-1:0] interval;
   } req_type;

   typedef struct packed {
      logic [CoilWidth-1:0] coils;
      logic                 stepped;
      logic                 busy_res;
      logic                 accepted;
   } rsp_type;

   // Contents of the input stage handed to the sequencing core.
   typedef struct packed {
      logic                     valid;
      req_type                  req;
      logic [ProdQWidth-1:0]    prod_q;
      logic [ProdRWidth-1:0]    prod_r;
   } stage_type;

   // Scale factors derived from steps_per_rev.
   typedef struct packed {
      logic [SprQuotWidth-1:0] quot;
      logic [SprRemWidth-1:0]  rem;
   } scale_type;

   // Half-step coil drive sequence.
   function automatic logic [CoilWidth-1:0] coil_pattern(input logic [PhaseWidth-1:0] idx);
      logic [CoilWidth-1:0] pattern;
      unique case (idx)
         3'd0: pattern = 4'h4;
         3'd1: pattern = 4'h6;
         3'd2: pattern = 4'h2;
         3'd3: pattern = 4'h3;
         3'd4: pattern = 4'h1;
         3'd5: pattern = 4'h9;
         3'd6: pattern = 4'h8;
         3'd7: pattern = 4'hC;
         default: pattern = 4'h4;
      endcase
      return pattern;
   endfunction

endpackage

// ===== src/stepper_move_sequencer.sv =====
// Top level of the stepper move sequencer: four-coil half-step drive with move commands.
`timescale 1ns / 1ps

// The sequencer drives four stepper coils from an eight-entry half-step phase table. Each
// request transfer is either a move command or one time tick, and each produces exactly one
// response transfer carrying the coil pattern after the item, whether it stepped, whether the
// motor is still busy, and whether a move command was taken. A move command is taken only
// while idle; degree moves are converted with the steps_per_rev register, which may be written
// only while the block is idle. One item is accepted per clock cycle while the pipeline is
// not stalled: an item is held in the input register, where the degree conversion products
// are formed, and is resolved against the motion state as it is loaded into the response
// register. The rate is set by the update of the motion state that each item needs from its
// predecessor. The response register lets a new request transfer happen while a finished
// response still waits on rsp_stall.

module stepper_move_sequencer import smsq_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_payload,
   input  logic                csr_wr_en,
   input  logic [SprWidth-1:0] csr_wr_data
);

   scale_type scale;
   stage_type stage;
   logic      core_ready;

   // steps_per_rev is kept as its quotient and remainder by 360.
   smsq_cfg u_cfg (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .scale       (scale)
   );

   // Input register with the degree partial products.
   smsq_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .scale       (scale),
      .core_ready  (core_ready),
      .stage       (stage)
   );

   // Motion state and response register.
   smsq_core u_core (
      .clock       (clock),
      .reset       (reset),
      .stage       (stage),
      .core_ready  (core_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // Every step reloads a wait of at least one tick, so a stepping response is busy.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.stepped |-> rsp_payload.busy_res)
      else $error("stepping response not marked busy");

   // A taken command that did not step had a zero count and leaves the motor idle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.accepted && !rsp_payload.stepped |-> !rsp_payload.busy_res)
      else $error("zero-count move left the motor busy");

   // The request side stalls only while an item occupies the input register.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> stage.valid && rsp_valid)
      else $error("request stalled with room in the pipeline");

   // An item in the input register reaches the response register unless the output stalls.
   assert property (@(posedge clock) disable iff (reset)
      stage.valid && !rsp_stall |=> rsp_valid)
      else $error("input item not moved to the response register");

endmodule

// ===== src/smsq_cfg.sv =====
// Configuration register: holds steps_per_rev as its quotient and remainder by 360.
`timescale 1ns / 1ps

module smsq_cfg import smsq_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [SprWidth-1:0] csr_wr_data,
   output scale_type           scale
);

   logic [SprQuotWidth-1:0] quot_ff, quot_in;
   logic [SprRemWidth-1:0]  rem_ff, rem_in;
   logic [27:0]             recip_prod;
   logic [SprWidth:0]       quot_times_360;
   logic [SprWidth:0]       rem_wide;

   always_comb begin
      // Divide by 8 first, then by 45 through the reciprocal.
      recip_prod     = 28'(csr_wr_data[SprWidth-1:3]) * 28'(CFG_RECIP_45);
      quot_in        = recip_prod[CfgRecipShift+SprQuotWidth-1:CfgRecipShift];
      quot_times_360 = ((SprWidth+1)'(quot_in) << 8) + ((SprWidth+1)'(quot_in) << 6)
                     + ((SprWidth+1)'(quot_in) << 5) + ((SprWidth+1)'(quot_in) << 3);
      rem_wide       = (SprWidth+1)'(csr_wr_data) - quot_times_360;
      rem_in         = rem_wide[SprRemWidth-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quot_ff <= '0;
         rem_ff  <= SPR_REM_RESET;
      end else if (csr_wr_en) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
      end
   end

   assign scale.quot = quot_ff;
   assign scale.rem  = rem_ff;

endmodule

// ===== src/smsq_front.sv =====
// Input stage: registers the command and the two partial products of the degree conversion.
`timescale 1ns / 1ps

module smsq_front import smsq_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_stall,
   input  req_type   req_payload,
   input  scale_type scale,
   input  logic      core_ready,
   output stage_type stage
);

   logic                  valid_ff, valid_in;
   req_type               req_ff;
   logic [ProdQWidth-1:0] prod_q_ff;
   logic [ProdRWidth-1:0] prod_r_ff;
   logic                  load;

   assign req_stall = valid_ff & ~core_ready;
   assign load      = req_valid & ~req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (core_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         req_ff    <= req_payload;
         prod_q_ff <= ProdQWidth'(req_payload.amount) * ProdQWidth'(scale.quot);
         prod_r_ff <= ProdRWidth'(req_payload.amount) * ProdRWidth'(scale.rem);
      end
   end

   assign stage.valid  = valid_ff;
   assign stage.req    = req_ff;
   assign stage.prod_q = prod_q_ff;
   assign stage.prod_r = prod_r_ff;

endmodule

// ===== src/smsq_core.sv =====
// Sequencing core: motion state, step decision and the result register.
`timescale 1ns / 1ps

module smsq_core import smsq_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  stage_type stage,
   output logic      core_ready,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output rsp_type   rsp_payload
);

   logic [PhaseWidth-1:0]    phase_ff, phase_in;
   logic [StepsWidth-1:0]    steps_ff, steps_in;
   logic [IntervalWidth-1:0] wait_ff, wait_in;
   logic [IntervalWidth-1:0] hold_ff, hold_in;
   logic [PhaseWidth-1:0]    delta_ff, delta_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic                     go;
   logic                     idle;
   logic [60:0]              quo_prod;
   logic [24:0]              rem_quot;
   logic [DegCountWidth-1:0] deg_count;
   logic [DegCountWidth-1:0] base_count;
   logic [StepsWidth-1:0]    move_count;
   logic [PhaseWidth-1:0]    move_delta;
   logic [IntervalWidth-1:0] move_hold;
   logic [IntervalWidth-1:0] tick_wait;

   assign core_ready = ~rsp_valid_ff | ~rsp_stall;
   assign go         = stage.valid & core_ready;

   always_comb begin
      // Degree count: amount * quot + floor(amount * rem / 360).
      quo_prod   = 61'(stage.prod_r[ProdRWidth-1:3]) * 61'(RECIP_45);
      rem_quot   = quo_prod[Recip45Shift+24:Recip45Shift];
      deg_count  = DegCountWidth'(stage.prod_q) + DegCountWidth'(rem_quot);
      base_count = stage.req.in_degrees ? deg_count : DegCountWidth'(stage.req.amount);
      move_count = stage.req.half_mode ? {base_count, 1'b0} : {1'b0, base_count};
      move_delta = stage.req.half_mode ? DELTA_HALF : DELTA_FULL;
      if (stage.req.counter_clockwise) begin
         move_delta = 3'd0 - move_delta;
      end
      move_hold  = (stage.req.interval == '0) ? IntervalWidth'(1) : stage.req.interval;
      tick_wait  = (wait_ff != '0) ? wait_ff - IntervalWidth'(1) : wait_ff;
      idle       = (steps_ff == '0) && (wait_ff == '0);

      phase_in = phase_ff;
      steps_in = steps_ff;
      wait_in  = wait_ff;
      hold_in  = hold_ff;
      delta_in = delta_ff;
      rsp_in   = '0;

      unique case (stage.req.action)
         ACTION_MOVE: begin
            if (idle) begin
               rsp_in.accepted = 1'b1;
               delta_in        = move_delta;
               hold_in         = move_hold;
               steps_in        = move_count;
               if (move_count != '0) begin
                  phase_in       = phase_ff + move_delta;
                  steps_in       = move_count - StepsWidth'(1);
                  wait_in        = move_hold;
                  rsp_in.stepped = 1'b1;
               end
            end
         end
         ACTION_TICK: begin
            wait_in = tick_wait;
            if (tick_wait == '0 && steps_ff != '0) begin
               phase_in       = phase_ff + delta_ff;
               steps_in       = steps_ff - StepsWidth'(1);
               wait_in        = hold_ff;
               rsp_in.stepped = 1'b1;
            end
         end
         default: begin
            rsp_in.accepted = 1'b0;
         end
      endcase

      rsp_in.coils    = coil_pattern(phase_in);
      rsp_in.busy_res = (steps_in != '0) || (wait_in != '0);

      rsp_valid_in = rsp_valid_ff;
      if (go) begin
         rsp_valid_in = 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         steps_ff     <= '0;
         wait_ff      <= '0;
         hold_ff      <= '0;
         delta_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (go) begin
            phase_ff <= phase_in;
            steps_ff <= steps_in;
            wait_ff  <= wait_in;
            hold_ff  <= hold_in;
            delta_ff <= delta_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
